### rtl/fp8_conv_pkg.sv
// Shared types and constants for the FP8 format converter.
// No dependencies.
package fp8_conv_pkg;

   localparam logic [30:0] E4M3_MAX_MAG = 31'h43E00000;
   localparam logic [30:0] E5M2_MAX_MAG = 31'h47600000;
   localparam logic [6:0]  E4M3_MAX_CODE = 7'h7E;
   localparam logic [6:0]  E5M2_MAX_CODE = 7'h7B;
   localparam logic [7:0]  E4M3_NAN_CODE = 8'h00;
   localparam logic [7:0]  E5M2_NAN_CODE = 8'h7F;
   localparam logic        KIND_ENCODE = 1'b0;
   localparam logic        KIND_DECODE = 1'b1;

   typedef struct packed {
      logic [31:0] result_bits;
      logic        saturated;
      logic        invalid_input;
   } result_type;

endpackage

### rtl/fp8_conv_encode.sv
// Single to FP8 encoder, combinational.
// Depends on fp8_conv_pkg.
module fp8_conv_encode (
   input  logic                      e5m2,
   input  logic [31:0]               x,
   output fp8_conv_pkg::result_type  res
);

   logic        sign;
   logic [30:0] mag;
   logic [7:0]  bexp;
   logic [23:0] sig;
   logic [8:0]  e;
   logic [8:0]  emin;
   logic [4:0]  mbits;
   logic [8:0]  shift;
   logic        normal;
   logic [24:0] rnd;
   logic [24:0] n;
   logic [7:0]  code;

   always_comb begin
      sign   = x[31];
      mag    = x[30:0];
      bexp   = mag[30:23];
      sig    = {1'b1, mag[22:0]};
      // signed exponent arithmetic in 9 bits
      e      = {1'b0, bexp} - 9'd127;
      emin   = e5m2 ? -9'sd14 : -9'sd6;
      mbits  = e5m2 ? 5'd2 : 5'd3;
      normal = ($signed(e) >= $signed(emin));
      shift  = normal ? (9'd23 - {4'd0, mbits})
                      : (emin - {4'd0, mbits} - e + 9'd23);
      rnd    = '0;
      n      = '0;
      if ($signed(shift) <= 9'sd25 && $signed(shift) >= 9'sd1) begin
         rnd = 25'd1 << (shift[4:0] - 5'd1);
         n   = ({1'b0, sig} + rnd) >> shift[4:0];
      end
      if (normal)
         code = 8'((e - emin) << mbits) + n[7:0];
      else
         code = n[7:0];

      res = '0;
      if (bexp == 8'hFF && mag[22:0] != 23'd0) begin
         res.invalid_input = 1'b1;
         res.result_bits   = {24'd0, e5m2 ? fp8_conv_pkg::E5M2_NAN_CODE
                                          : fp8_conv_pkg::E4M3_NAN_CODE};
      end else if (mag > (e5m2 ? fp8_conv_pkg::E5M2_MAX_MAG
                               : fp8_conv_pkg::E4M3_MAX_MAG)) begin
         res.saturated   = 1'b1;
         res.result_bits = {24'd0, sign, e5m2 ? fp8_conv_pkg::E5M2_MAX_CODE
                                             : fp8_conv_pkg::E4M3_MAX_CODE};
      end else if (bexp != 8'd0 && $signed(shift) <= 9'sd25 && n != 25'd0) begin
         res.result_bits = {24'd0, sign, code[6:0]};
      end
   end

endmodule

### rtl/fp8_conv_decode.sv
// FP8 to single decoder, combinational.
// Depends on fp8_conv_pkg.
module fp8_conv_decode (
   input  logic                      e5m2,
   input  logic [7:0]                c,
   output fp8_conv_pkg::result_type  res
);

   logic       s;
   logic [4:0] ex;
   logic [2:0] m;
   logic [1:0] p;
   logic [2:0] frac;
   logic [7:0] sexp;

   always_comb begin
      s  = c[7];
      ex = e5m2 ? c[6:2] : {1'b0, c[6:3]};
      m  = e5m2 ? {1'b0, c[1:0]} : c[2:0];
      // subnormal: leading one position
      p    = m[2] ? 2'd2 : (m[1] ? 2'd1 : 2'd0);
      frac = m - (3'd1 << p);
      sexp = {6'd0, p} + (e5m2 ? 8'd111 : 8'd118);
      res  = '0;
      res.result_bits[31] = s;
      if (ex == 5'd0) begin
         if (m != 3'd0)
            res.result_bits[30:0] = {sexp, frac << (3'd3 - {1'b0, p}), 20'd0};
      end else if (!e5m2) begin
         if (!(ex == 5'hF && m == 3'h7))
            res.result_bits[30:0] = {8'({3'd0, ex} + 8'd120), m, 20'd0};
      end else if (ex == 5'h1F) begin
         res.result_bits[30:0] = (m == 3'd0) ? 31'h7F800000 : 31'h7FC00000;
      end else begin
         res.result_bits[30:0] = {8'({3'd0, ex} + 8'd112), m[1:0], 21'd0};
      end
   end

endmodule

### rtl/fp8_format_converter_core.sv
// FP8 format converter top level: input register, convert logic, result register.
// Depends on fp8_conv_pkg, fp8_conv_encode, fp8_conv_decode.
// rsp_valid is driven by the result register, loaded from the convert logic.
// Throughput: one transfer per cycle while rsp_ready stays high; req_ready drops
// only when both registers hold items and rsp_ready is low.
// Reset: synchronous active high; clears valids and the format register fmt_ff to E4M3.
module fp8_format_converter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [31:0] req_value_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result_bits,
   output logic        rsp_saturated,
   output logic        rsp_invalid_input,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   logic        fmt_ff, fmt_in;
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_kind_ff;
   logic [31:0] s1_bits_ff;
   logic        s2_valid_ff, s2_valid_in;
   fp8_conv_pkg::result_type s2_res_ff, s2_res_in, enc_res, dec_res;
   logic        s1_adv, s2_free;

   fp8_conv_encode u_enc (.e5m2(fmt_ff), .x(s1_bits_ff), .res(enc_res));
   fp8_conv_decode u_dec (.e5m2(fmt_ff), .c(s1_bits_ff[7:0]), .res(dec_res));

   // pipeline flow control
   always_comb begin
      s2_free     = !s2_valid_ff || rsp_ready;
      s1_adv      = s1_valid_ff && s2_free;
      req_ready   = !s1_valid_ff || s2_free;
      s1_valid_in = req_ready ? req_valid : s1_valid_ff;
      s2_valid_in = s2_free ? s1_valid_ff : s2_valid_ff;
      s2_res_in   = (s1_kind_ff == fp8_conv_pkg::KIND_DECODE) ? dec_res : enc_res;
      fmt_in      = csr_write_enable ? csr_write_data : fmt_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff      <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         fmt_ff      <= fmt_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_kind_ff <= req_kind;
         s1_bits_ff <= req_value_bits;
      end
      if (s1_adv)
         s2_res_ff <= s2_res_in;
   end

   assign rsp_valid         = s2_valid_ff;
   assign rsp_result_bits   = s2_res_ff.result_bits;
   assign rsp_saturated     = s2_res_ff.saturated;
   assign rsp_invalid_input = s2_res_ff.invalid_input;

endmodule

### verif/fp8_format_converter_core_test.sv
// Self-checking testbench for fp8_format_converter_core: encode/decode in both FP8 formats.
// Depends on fp8_conv_pkg and the fp8_format_converter_core RTL.
module fp8_format_converter_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = fp8_conv_pkg::KIND_ENCODE;
   logic [31:0] req_value_bits = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_result_bits;
   logic        rsp_saturated;
   logic        rsp_invalid_input;
   logic        csr_write_enable = 1'b0;
   logic        csr_write_data = 1'b0;

   bit fmt_e5m2;
   bit failed;
   bit rsp_idle_on = 1'b1;
   int stall_cycles;

   // Conversion predictor: expected FP8 or single results from format and input
   class conversion_scoreboard;
      fp8_conv_pkg::result_type pending[$];

      function automatic logic [31:0] to_fp8(logic [31:0] x, bit e5m2,
                                             output logic sat, output logic inv);
         logic        sgn;
         logic [30:0] mag;
         logic [7:0]  bexp;
         int          mbits, emin, e, shift;
         logic [31:0] sig, n, code;
         sgn = x[31];
         mag = x[30:0];
         bexp = mag[30:23];
         mbits = e5m2 ? 2 : 3;
         emin = e5m2 ? -14 : -6;
         sat = 1'b0;
         inv = 1'b0;
         if (bexp == 8'hFF && mag[22:0] != 0) begin
            inv = 1'b1;
            return e5m2 ? 32'(fp8_conv_pkg::E5M2_NAN_CODE)
                        : 32'(fp8_conv_pkg::E4M3_NAN_CODE);
         end
         if (mag > (e5m2 ? fp8_conv_pkg::E5M2_MAX_MAG : fp8_conv_pkg::E4M3_MAX_MAG)) begin
            sat = 1'b1;
            return {24'b0, sgn, e5m2 ? fp8_conv_pkg::E5M2_MAX_CODE
                                     : fp8_conv_pkg::E4M3_MAX_CODE};
         end
         if (bexp == 0) return 32'b0;
         e = int'(bexp) - 127;
         sig = {9'b1, mag[22:0]};
         shift = (e >= emin) ? 23 - mbits : emin - mbits - e + 23;
         if (shift > 25) return 32'b0;
         n = (sig + (32'd1 << (shift - 1))) >> shift;
         if (n == 0) return 32'b0;
         code = (e >= emin) ? ((32'(e - emin) << mbits) + n) : n;
         return {24'b0, sgn, code[6:0]};
      endfunction

      // Subnormal FP8 mantissa to normalized single
      function automatic logic [31:0] denorm_single(logic [2:0] m, int scale);
         int p;
         p = m[2] ? 2 : (m[1] ? 1 : 0);
         return (32'(p + scale + 127) << 23) | ((32'(m) - (32'd1 << p)) << (23 - p));
      endfunction

      function automatic logic [31:0] from_fp8(logic [7:0] c, bit e5m2);
         logic [31:0] s;
         logic [4:0]  ex;
         logic [2:0]  m;
         s = {c[7], 31'b0};
         if (!e5m2) begin
            ex = {1'b0, c[6:3]};
            m = c[2:0];
            if (ex == 0) return (m == 0) ? s : (s | denorm_single(m, -9));
            if (ex == 5'hF && m == 3'h7) return s;
            return s | (32'(ex + 120) << 23) | (32'(m) << 20);
         end
         ex = c[6:2];
         m = {1'b0, c[1:0]};
         if (ex == 0) return (m == 0) ? s : (s | denorm_single(m, -16));
         if (ex == 5'h1F) return (m == 0) ? (s | 32'h7F800000) : (s | 32'h7FC00000);
         return s | (32'(ex + 112) << 23) | (32'(m) << 21);
      endfunction

      function void note_request(logic kind, logic [31:0] bits, bit e5m2);
         fp8_conv_pkg::result_type r;
         logic sat, inv;
         if (kind == fp8_conv_pkg::KIND_ENCODE) begin
            r.result_bits = to_fp8(bits, e5m2, sat, inv);
            r.saturated = sat;
            r.invalid_input = inv;
         end else begin
            r.result_bits = from_fp8(bits[7:0], e5m2);
            r.saturated = 1'b0;
            r.invalid_input = 1'b0;
         end
         pending.push_back(r);
      endfunction

      function bit check_response(logic [31:0] bits, logic sat, logic inv);
         fp8_conv_pkg::result_type x;
         bit bad;
         bad = 1'b0;
         if (pending.size() == 0) begin
            $display("%0t: unexpected transfer: result %h sat %b inv %b",
                     $time, bits, sat, inv);
            return 1'b1;
         end
         x = pending.pop_front();
         if (bits !== x.result_bits) begin
            $display("%0t: result_bits expected %h actual %h", $time, x.result_bits, bits);
            bad = 1'b1;
         end
         if (sat !== x.saturated) begin
            $display("%0t: saturated expected %b actual %b", $time, x.saturated, sat);
            bad = 1'b1;
         end
         if (inv !== x.invalid_input) begin
            $display("%0t: invalid_input expected %b actual %b",
                     $time, x.invalid_input, inv);
            bad = 1'b1;
         end
         return bad;
      endfunction
   endclass

   conversion_scoreboard board = new();

   fp8_format_converter_core DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Monitor both channels at the edge; predictions use the format in force
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_request(req_kind, req_value_bits, fmt_e5m2);
         if (rsp_valid && rsp_ready)
            if (board.check_response(rsp_result_bits, rsp_saturated, rsp_invalid_input))
               failed = 1'b1;
      end
   end

   // Receiver: random stall bursts, free-running once idling is switched off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (!rsp_idle_on) begin
         rsp_ready <= 1'b1;
      end else if (stall_cycles > 0) begin
         stall_cycles <= stall_cycles - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_cycles <= $urandom_range(1, 18) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: cycles with no transfer on either channel
   int quiet_cycles;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** fp8_format_converter_core: FAILED **");
            $finish;
         end
      end
   end

   task automatic send_item(logic kind, logic [31:0] bits, bit allow_gap);
      int gap;
      if (allow_gap && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_value_bits <= bits;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_format(bit e5m2);
      csr_write_enable <= 1'b1;
      csr_write_data <= e5m2;
      @(posedge clock);
      fmt_e5m2 = e5m2;
      csr_write_enable <= 1'b0;
   endtask

   // Value generator biased toward the interesting FP8 ranges
   function automatic logic [31:0] pick_value(logic kind);
      logic [31:0] v;
      v = $urandom;
      if (kind == fp8_conv_pkg::KIND_DECODE) return v;
      case ($urandom_range(0, 7))
         0, 1, 2: v[30:23] = 8'($urandom_range(127 - 28, 127 + 17));
         3:       v[30:23] = 8'($urandom_range(127 - 28, 127 - 6));
         4:       v[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         5:       begin
            v[30:23] = 8'($urandom_range(127 + 7, 127 + 16));
            v[22:18] = 5'h1F;
         end
         6:       v[17:0] = $urandom_range(0, 1) ? 18'h20000 : 18'h1FFFF;
         default: ;
      endcase
      return v;
   endfunction

   localparam logic [31:0] DIRECTED[16] = '{
      32'h00000000, 32'h80000000, 32'h00000001, 32'h7F800000, 32'hFF800000,
      32'h7FC00000, 32'hFF800001, 32'h43E00000, 32'h43E00001, 32'hC7600000,
      32'h47600001, 32'h3B100000, 32'h37800000, 32'h43F00000, 32'h3F7FFFFF,
      32'h33000000};

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      fmt_e5m2 = 1'b0;
      @(posedge clock);
      // Directed: extremes and special encodes/decodes in both formats
      for (int f = 0; f < 2; f++) begin
         write_format(f[0]);
         foreach (DIRECTED[i])
            send_item(fp8_conv_pkg::KIND_ENCODE, DIRECTED[i], 1'b0);
         foreach (DIRECTED[i])
            send_item(fp8_conv_pkg::KIND_DECODE, {DIRECTED[i][31:8], 8'(i * 17)}, 1'b0);
         send_item(fp8_conv_pkg::KIND_DECODE, 32'hFFFFFF7F, 1'b0);
         send_item(fp8_conv_pkg::KIND_DECODE, 32'h000000FF, 1'b0);
         send_item(fp8_conv_pkg::KIND_DECODE, 32'h0000007C, 1'b0);
         send_item(fp8_conv_pkg::KIND_DECODE, 32'h000000FC, 1'b0);
         drain();
      end
      // Random phases, format picked at random before each; the last runs in E4M3
      for (int ph = 0; ph < 7; ph++) begin
         write_format(ph == 6 ? 1'b0 : 1'($urandom_range(0, 1)));
         for (int i = 0; i < 200; i++) begin
            logic kind;
            kind = 1'($urandom_range(0, 1));
            if (ph == 6) rsp_idle_on = 1'b0;
            send_item(kind, pick_value(kind), ph != 6);
         end
         drain();
      end
      if (!failed && board.pending.size() == 0) begin
         $display("** fp8_format_converter_core: PASSED **");
      end else begin
         $display("** fp8_format_converter_core: FAILED **");
      end
      $finish;
   end
endmodule
